>>> rtl/usm_pkg.sv
// ---------------------------------------------------------------------------
// usm_pkg: shared types and constants of the 3x3 unsharp mask
// Pixel and register widths, register indexes, request kinds and the result
// record that travels from the filter datapath into the output queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package usm_pkg;

  // Sample and register widths.
  localparam int PIX_W   = 8;
  localparam int FW_W    = 12;
  localparam int FH_W    = 16;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Request kinds carried on the input tuser bit.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // Largest output sample after clamping.
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hff;

  // Depth of the output queue; it absorbs the results still in the pipeline.
  localparam int OUT_DEPTH = 8;

  // One result request.
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pixel;
  } usm_result_t;

endpackage

`default_nettype wire

>>> rtl/unsharp_mask_3x3.sv
// ---------------------------------------------------------------------------
// unsharp_mask_3x3: streaming 3x3 unsharp mask for one 8-bit channel
// Two line buffers (one RAM, upper and lower row side by side) and a 3x3
// window feed 2*centre - gaussian blur, clamped; border pixels are copied.
// ---------------------------------------------------------------------------
//
//  Channel  | Signals                         | Carries
//  ---------+---------------------------------+------------------------------
//  s_axis   | tvalid tready tdata tuser       | pixel_in, action (pixel/drain)
//  m_axis   | tvalid tready tdata tlast       | pixel_out, frame_last
//  apb      | psel penable pwrite paddr ...   | frame_width, frame_height
//
//  One request is accepted per clock while s_axis_tready is high. A result
//  reaches the output queue after the request that completes its window
//  passes a line buffer read, a window shift, a row-sum stage and a clamp stage.
//  Back-to-back requests at the same line buffer column (frame width one)
//  are served by forwarding the write data of the previous request.
//  s_axis_tready drops only when the output queue and the requests in
//  flight could overfill the queue, so stalls come from m_axis alone.
//  Reset clears counters and the window; the line buffer RAM is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unsharp_mask_3x3
  import usm_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Input stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [PIX_W-1:0]  s_axis_tdata,   // [7:0] pixel_in
  input  wire logic              s_axis_tuser,   // [0] action
  // Output stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [PIX_W-1:0]  m_axis_tdata,   // [7:0] pixel_out
  output logic                   m_axis_tlast,
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int LW    = $clog2(MAX_WIDTH + 2);
  localparam int LINE_W = 2 * PIX_W;
  localparam int RS_W  = PIX_W + 2;
  localparam int SUM_W = PIX_W + 4;
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
  localparam int RDY_W  = OCNT_W + 1;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_W'(640);
      frame_height_q <= FH_W'(480);
    end else if (cfg_we) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
        default:          frame_width_q  <= frame_width_q;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  // Effective frame size: width clamped to 1..MAX_WIDTH, height at least 1.
  logic [CW-1:0]   w_eff, w_m1;
  logic [FH_W-1:0] h_eff, h_m1;

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = CW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width_q);
    end
    w_m1  = w_eff - CW'(1);
    h_eff = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
    h_m1  = h_eff - FH_W'(1);
  end

  // -------------------------------------------------------------------------
  // Request stage: position counters, line buffer read
  // -------------------------------------------------------------------------
  logic [AW-1:0]   in_col_q, in_col_d;
  logic [FH_W-1:0] in_row_q, in_row_d;
  logic [AW-1:0]   out_col_q, out_col_d;
  logic [FH_W-1:0] out_row_q, out_row_d;
  logic [LW-1:0]   lead_q, lead_d;

  logic            in_acc, is_drain, draining, take;
  logic [AW-1:0]   col_sel;
  logic [CW-1:0]   col_inc, ocol_inc;
  logic            col_wrap, ocol_wrap;
  logic            lead_full, emit, out_border, out_lastpos;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign is_drain  = (s_axis_tuser == ACT_DRAIN);
  assign draining  = (in_row_q >= h_eff);
  assign take      = in_acc && (is_drain == draining);

  assign col_sel   = (CW'(in_col_q) >= w_eff) ? '0 : in_col_q;
  assign col_inc   = CW'(col_sel) + CW'(1);
  assign col_wrap  = (col_inc >= w_eff);

  assign lead_full = (lead_q >= (LW'(w_eff) + LW'(1)));
  assign emit      = take && lead_full;

  assign out_border  = (out_row_q == '0) || (out_row_q >= h_m1) ||
                       (out_col_q == '0) || (CW'(out_col_q) >= w_m1);
  assign out_lastpos = (out_row_q >= h_m1) && (CW'(out_col_q) >= w_m1);
  assign ocol_inc    = CW'(out_col_q) + CW'(1);
  assign ocol_wrap   = (ocol_inc >= w_eff);

  // Counter next state; a register write or the last result restarts the frame.
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lead_d    = lead_q;
    if (cfg_we) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      lead_d    = '0;
    end else if (take) begin
      in_col_d = col_wrap ? '0 : col_inc[AW-1:0];
      if (col_wrap && !is_drain) begin
        in_row_d = in_row_q + FH_W'(1);
      end
      if (!lead_full) begin
        lead_d = lead_q + LW'(1);
      end else if (out_lastpos) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
        lead_d    = '0;
      end else begin
        out_col_d = ocol_wrap ? '0 : ocol_inc[AW-1:0];
        if (ocol_wrap) begin
          out_row_d = out_row_q + FH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lead_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lead_q    <= lead_d;
    end
  end

  // -------------------------------------------------------------------------
  // Line buffer RAM: {upper, lower} per column, read-modify-write
  // -------------------------------------------------------------------------
  logic              s1_vld_q;
  logic              s1_drain_q, s1_emit_q, s1_border_q, s1_last_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic [AW-1:0]     s1_addr_q;
  logic              fwd_hit_q;
  logic [LINE_W-1:0] fwd_data_q;
  logic [LINE_W-1:0] ram_rdata, line_rd, line_wdata;
  logic              line_we;
  logic [PIX_W-1:0]  up_pix, mid_pix, new_pix;

  assign line_rd    = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign up_pix     = line_rd[LINE_W-1:PIX_W];
  assign mid_pix    = line_rd[PIX_W-1:0];
  assign new_pix    = s1_drain_q ? '0 : s1_pix_q;
  assign line_we    = s1_vld_q && !s1_drain_q;
  assign line_wdata = {mid_pix, s1_pix_q};

  usm_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wdata),
    .re_i    (take),
    .raddr_i (col_sel),
    .rdata_o (ram_rdata)
  );

  // Stage 1 control and the forwarding path for a same-column write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      s1_vld_q  <= take;
      fwd_hit_q <= line_we && (s1_addr_q == col_sel);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= line_wdata;
    if (take) begin
      s1_drain_q  <= is_drain;
      s1_pix_q    <= s_axis_tdata;
      s1_addr_q   <= col_sel;
      s1_emit_q   <= emit;
      s1_border_q <= out_border;
      s1_last_q   <= out_lastpos;
    end
  end

  // -------------------------------------------------------------------------
  // 3x3 window shift
  // -------------------------------------------------------------------------
  logic [PIX_W-1:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_vld_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]     <= win_q[r*3 + 1];
        win_q[r*3 + 1] <= win_q[r*3 + 2];
      end
      win_q[2] <= up_pix;
      win_q[5] <= mid_pix;
      win_q[8] <= new_pix;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: row sums of the window (1 2 1 weights)
  // -------------------------------------------------------------------------
  logic             s2_vld_q, s2_border_q, s2_last_q;
  logic             s3_vld_q, s3_border_q, s3_last_q;
  logic [RS_W-1:0]  row_sum [3];
  logic [RS_W-1:0]  s3_rs_q [3];
  logic [PIX_W-1:0] s3_ctr_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = RS_W'(win_q[r*3]) + {1'b0, win_q[r*3 + 1], 1'b0} +
                   RS_W'(win_q[r*3 + 2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q && s1_emit_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_border_q <= s1_border_q;
    s2_last_q   <= s1_last_q;
    s3_border_q <= s2_border_q;
    s3_last_q   <= s2_last_q;
    s3_ctr_q    <= win_q[4];
    for (int r = 0; r < 3; r++) begin
      s3_rs_q[r] <= row_sum[r];
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: blur, 2*centre - blur, clamp, border copy
  // -------------------------------------------------------------------------
  logic [SUM_W-1:0] blur_sum;
  logic [PIX_W-1:0] blur;
  logic [PIX_W+1:0] sharp_diff;
  logic [PIX_W-1:0] sharp_pix;
  usm_result_t      res;

  always_comb begin
    blur_sum   = SUM_W'(s3_rs_q[0]) + SUM_W'({s3_rs_q[1], 1'b0}) + SUM_W'(s3_rs_q[2]);
    blur       = blur_sum[SUM_W-1:4];
    sharp_diff = {1'b0, s3_ctr_q, 1'b0} - {2'b00, blur};
    if (sharp_diff[PIX_W+1]) begin
      sharp_pix = '0;
    end else if (sharp_diff[PIX_W]) begin
      sharp_pix = PIX_MAX;
    end else begin
      sharp_pix = sharp_diff[PIX_W-1:0];
    end
    res.pixel = s3_border_q ? s3_ctr_q : sharp_pix;
    res.last  = s3_last_q;
  end

  // -------------------------------------------------------------------------
  // Output queue and input back-pressure
  // -------------------------------------------------------------------------
  usm_result_t       out_res;
  logic [OCNT_W-1:0] out_cnt;
  logic [RDY_W-1:0]  pending;

  usm_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_vld_q),
    .push_data_i (res),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .count_o     (out_cnt)
  );

  // Queue entries plus results still in the pipeline must leave room for one more.
  assign pending = RDY_W'(out_cnt) + RDY_W'(s1_vld_q && s1_emit_q) +
                   RDY_W'(s2_vld_q) + RDY_W'(s3_vld_q);
  assign s_axis_tready = (pending < RDY_W'(OUT_DEPTH));

  assign m_axis_tdata = out_res.pixel;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

>>> rtl/usm_ram.sv
// ---------------------------------------------------------------------------
// usm_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle. A read of the address being
// written in the same cycle returns the old contents.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usm_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 2048,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/usm_out_fifo.sv
// ---------------------------------------------------------------------------
// usm_out_fifo: result queue in front of the output stream
// Holds finished results so that the filter pipeline never has to stop;
// the input side watches the fill level and holds off new requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usm_out_fifo
  import usm_pkg::*;
#(
  parameter int  DEPTH = 8,
  localparam int PW    = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire usm_result_t       push_data_i,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output usm_result_t            data_o,
  output logic       [CNT_W-1:0] count_o
);

  usm_result_t      mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

>>> rtl/usm_checker.sv
// ---------------------------------------------------------------------------
// usm_checker: port-level checks of the unsharp mask
// Watches the stream ports and flags output stalls that change data,
// results without a matching request, and input stalls with no cause.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // A stalled result stays offered.
  a_out_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its payload.
  a_out_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // A result appearing on an empty output was requested by an earlier accepted input.
  a_out_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 4))
    else $error("result appeared without a matching request");

  // The input is held off only while results are waiting downstream.
  a_in_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

endmodule

bind unsharp_mask_3x3 usm_checker u_usm_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for the streaming 3x3 unsharp mask
// Drives pixel and drain requests with random gaps, stalls the output at
// random and predicts every result from a model of the line buffers, the
// window and the position counters. Frame sizes are set over APB and read
// back. A short table of hand-built frames comes first, then random frames.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import usm_pkg::*;

  localparam int          MAX_W         = 2048;
  localparam int unsigned RANDOM_ITEMS  = 1950;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // How a row of the hand-built table is checked.
  typedef enum logic [1:0] {
    CHK_NONE,
    CHK_FIXED,
    CHK_MODEL
  } check_e;

  // Pixel patterns used for random frames.
  typedef enum logic [1:0] {
    PAT_NOISE,
    PAT_RAILS,
    PAT_FLAT,
    PAT_CHECKER
  } pattern_e;

  typedef struct {
    logic             act;
    logic [PIX_W-1:0] pix;
    check_e           chk;
    logic [PIX_W-1:0] want_pixel;
    logic             want_last;
  } probe_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [PIX_W-1:0]  s_axis_tdata = '0;   // [7:0] pixel_in
  logic              s_axis_tuser = 1'b0; // [0] action
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [PIX_W-1:0]  m_axis_tdata;        // [7:0] pixel_out
  logic              m_axis_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Predictor state: configuration, line buffers, window and counters.
  logic [FW_W-1:0]  width_reg = FW_W'(640);
  logic [FH_W-1:0]  height_reg = FH_W'(480);
  logic [PIX_W-1:0] above_line [MAX_W];
  logic [PIX_W-1:0] near_line [MAX_W];
  logic [PIX_W-1:0] win [9];
  int unsigned      src_col = 0;
  int unsigned      src_row = 0;
  int unsigned      dst_col = 0;
  int unsigned      dst_row = 0;
  int unsigned      warmup = 0;

  usm_result_t      awaited_pixels [$];
  usm_result_t      head;
  int unsigned      errors = 0;
  int unsigned      items_used = 0;
  int unsigned      cycles = 0;
  bit               src_calm = 1'b0;
  bit               sink_calm = 1'b0;

  // Two hand-built 3x3 frames. The first has a bright centre among dim
  // neighbours and clamps high; the second is its inverse and clamps low.
  // A drain in mid-frame and a pixel during the drain are both ignored.
  probe_t probe_rows [28] = '{
    '{ACT_PIXEL, 8'd1,   CHK_NONE,  8'd0,   1'b0},
    '{ACT_PIXEL, 8'd2,   CHK_NONE,  8'd0,   1'b0},
    '{ACT_PIXEL, 8'd4,   CHK_NONE,  8'd0,   1'b0},
    '{ACT_PIXEL, 8'd8,   CHK_NONE,  8'd0,   1'b0},
    '{ACT_PIXEL, 8'd255, CHK_FIXED, 8'd1,   1'b0},
    '{ACT_DRAIN, 8'd0,   CHK_NONE,  8'd0,   1'b0},
    '{ACT_PIXEL, 8'd16,  CHK_FIXED, 8'd2,   1'b0},
    '{ACT_PIXEL, 8'd32,  CHK_FIXED, 8'd4,   1'b0},
    '{ACT_PIXEL, 8'd64,  CHK_FIXED, 8'd8,   1'b0},
    '{ACT_PIXEL, 8'd128, CHK_MODEL, 8'd0,   1'b0},
    '{ACT_DRAIN, 8'd0,   CHK_FIXED, 8'd16,  1'b0},
    '{ACT_PIXEL, 8'h5a,  CHK_NONE,  8'd0,   1'b0},
    '{ACT_DRAIN, 8'd0,   CHK_FIXED, 8'd32,  1'b0},
    '{ACT_DRAIN, 8'd0,   CHK_FIXED, 8'd64,  1'b0},
    '{ACT_DRAIN, 8'd0,   CHK_FIXED, 8'd128, 1'b1},
    '{ACT_PIXEL, 8'd254, CHK_NONE,  8'd0,   1'b0},
    '{ACT_PIXEL, 8'd253, CHK_NONE,  8'd0,   1'b0},
    '{ACT_PIXEL, 8'd251, CHK_NONE,  8'd0,   1'b0},
    '{ACT_PIXEL, 8'd247, CHK_NONE,  8'd0,   1'b0},
    '{ACT_PIXEL, 8'd0,   CHK_FIXED, 8'd254, 1'b0},
    '{ACT_PIXEL, 8'd239, CHK_FIXED, 8'd253, 1'b0},
    '{ACT_PIXEL, 8'd223, CHK_FIXED, 8'd251, 1'b0},
    '{ACT_PIXEL, 8'd191, CHK_FIXED, 8'd247, 1'b0},
    '{ACT_PIXEL, 8'd127, CHK_MODEL, 8'd0,   1'b0},
    '{ACT_DRAIN, 8'd0,   CHK_FIXED, 8'd239, 1'b0},
    '{ACT_DRAIN, 8'd0,   CHK_FIXED, 8'd223, 1'b0},
    '{ACT_DRAIN, 8'd0,   CHK_FIXED, 8'd191, 1'b0},
    '{ACT_DRAIN, 8'd0,   CHK_FIXED, 8'd127, 1'b1}
  };

  unsharp_mask_3x3 #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[unsharp_mask_3x3] ERROR");
      $finish;
    end
  end

  // Effective frame sizes after clamping of the register values.
  function automatic int unsigned cols();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned rows();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  task automatic restart_positions();
    src_col = 0;
    src_row = 0;
    dst_col = 0;
    dst_row = 0;
    warmup  = 0;
  endtask

  // Advances the predictor by one accepted request. taken is low for a
  // request that the block ignores; emits is high when a result leaves.
  task automatic sharpen_predict(input logic act, input logic [PIX_W-1:0] pix,
                                 output usm_result_t res, output bit emits,
                                 output bit taken);
    int unsigned      w, h, c;
    logic [PIX_W-1:0] up, mid, fresh;
    int               blur, v;
    bit               drain_req;
    w = cols();
    h = rows();
    drain_req = (act == ACT_DRAIN);
    res = '0;
    emits = 1'b0;
    taken = 1'b0;
    // Drains only count once all pixels are in, pixels only before that.
    if (drain_req != (src_row >= h)) return;
    taken = 1'b1;
    c = (src_col >= w) ? 0 : src_col;
    up = above_line[c];
    mid = near_line[c];
    fresh = drain_req ? '0 : pix;
    if (!drain_req) begin
      above_line[c] = mid;
      near_line[c] = pix;
    end
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = fresh;
    c++;
    if (c >= w) begin
      c = 0;
      if (!drain_req) src_row++;
    end
    src_col = c;
    // The first results are held back until one row and one more pixel are in.
    if (warmup < w + 1) begin
      warmup++;
      return;
    end
    emits = 1'b1;
    if (dst_row == 0 || dst_row >= h - 1 || dst_col == 0 || dst_col >= w - 1) begin
      res.pixel = win[4];
    end else begin
      blur = (int'(win[0]) + 2*int'(win[1]) + int'(win[2])
            + 2*int'(win[3]) + 4*int'(win[4]) + 2*int'(win[5])
            + int'(win[6]) + 2*int'(win[7]) + int'(win[8])) >> 4;
      v = 2*int'(win[4]) - blur;
      if (v < 0) v = 0;
      if (v > int'(PIX_MAX)) v = int'(PIX_MAX);
      res.pixel = v[PIX_W-1:0];
    end
    res.last = (dst_row >= h - 1) && (dst_col >= w - 1);
    if (res.last) begin
      restart_positions();
    end else begin
      dst_col++;
      if (dst_col >= w) begin
        dst_col = 0;
        dst_row++;
      end
    end
  endtask

  // One APB transfer: setup phase, then access until pready.
  task automatic apb_access(input logic wr, input logic reg_sel,
                            input logic [APB_DW-1:0] data,
                            output logic [APB_DW-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_check(input logic reg_sel, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, reg_sel, '0, rd);
    if (rd !== want) begin
      $display("%0t ns: register %0d read expected %0h, got %0h",
               $time, reg_sel, want, rd);
      errors++;
    end
  endtask

  // Writes a frame size with junk above the field, then reads it back.
  task automatic cfg_write(input logic reg_sel, input int unsigned value);
    logic [APB_DW-1:0] mask, data, rd;
    mask = (reg_sel == REG_FRAME_WIDTH) ? (APB_DW'(1) << FW_W) - 1
                                        : (APB_DW'(1) << FH_W) - 1;
    data = ($urandom & ~mask) | (APB_DW'(value) & mask);
    apb_access(1'b1, reg_sel, data, rd);
    if (reg_sel == REG_FRAME_WIDTH) width_reg = data[FW_W-1:0];
    else height_reg = data[FH_W-1:0];
    restart_positions();
    read_check(reg_sel, data & mask);
  endtask

  // Offers one request after a random gap and predicts on acceptance.
  task automatic push_item(input logic act, input logic [PIX_W-1:0] pix,
                           input bit fixed, input usm_result_t fixed_res);
    int unsigned gap;
    usm_result_t res;
    bit          emits, taken;
    gap = src_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    sharpen_predict(act, pix, res, emits, taken);
    if (taken) items_used++;
    if (emits) awaited_pixels.push_back(fixed ? fixed_res : res);
  endtask

  // Lets every awaited result arrive and the pipeline run empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] frame_pixel(pattern_e pat, int unsigned base,
                                                   int unsigned idx);
    int v;
    case (pat)
      PAT_NOISE: return PIX_W'($urandom_range(0, 255));
      PAT_RAILS: return $urandom_range(0, 1) ? PIX_MAX : '0;
      PAT_FLAT: begin
        v = int'(base) + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
      end
      default: return idx[0] ? PIX_MAX : '0;
    endcase
  endfunction

  // Sets the frame size and sends whole frames, with stray requests mixed
  // in; a non-zero cap cuts the stream short to test a mid-frame restart.
  task automatic run_setting(input int unsigned wreg, input int unsigned hreg,
                             input int unsigned nframes, input int unsigned cap);
    int unsigned w, h, sent, base;
    pattern_e    pat;
    bit          stop;
    if ($urandom_range(0, 1)) begin
      cfg_write(REG_FRAME_WIDTH, wreg);
      cfg_write(REG_FRAME_HEIGHT, hreg);
    end else begin
      cfg_write(REG_FRAME_HEIGHT, hreg);
      cfg_write(REG_FRAME_WIDTH, wreg);
    end
    w = cols();
    h = rows();
    sent = 0;
    stop = 1'b0;
    src_calm  = ($urandom_range(0, 3) == 0);
    sink_calm = ($urandom_range(0, 3) == 0);
    for (int f = 0; f < int'(nframes) && !stop; f++) begin
      pat = pattern_e'($urandom_range(0, 3));
      base = $urandom_range(0, 255);
      for (int unsigned i = 0; i < w * h && !stop; i++) begin
        if ($urandom_range(0, 39) == 0)
          push_item(ACT_DRAIN, PIX_W'($urandom_range(0, 255)), 1'b0, '0);
        push_item(ACT_PIXEL, frame_pixel(pat, base, i), 1'b0, '0);
        sent++;
        stop = (cap != 0 && sent >= cap);
      end
      for (int unsigned d = 0; d <= w && !stop; d++) begin
        if ($urandom_range(0, 39) == 0)
          push_item(ACT_PIXEL, PIX_W'($urandom_range(0, 255)), 1'b0, '0);
        push_item(ACT_DRAIN, PIX_W'($urandom_range(0, 255)), 1'b0, '0);
        sent++;
        stop = (cap != 0 && sent >= cap);
      end
    end
    settle();
  endtask

  task automatic random_setting();
    int unsigned wreg, hreg, pick, cap;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       wreg = 0;
      1:       wreg = 1;
      2:       wreg = 2;
      3:       wreg = $urandom_range(13, 40);
      default: wreg = $urandom_range(3, 12);
    endcase
    pick = $urandom_range(0, 19);
    case (pick)
      0:       hreg = 0;
      1:       hreg = 1;
      2:       hreg = 2;
      default: hreg = $urandom_range(3, 6);
    endcase
    cap = 0;
    if ($urandom_range(0, 7) == 0)
      cap = $urandom_range(1, (wreg == 0 ? 1 : wreg) * (hreg == 0 ? 1 : hreg));
    run_setting(wreg, hreg, $urandom_range(1, 3), cap);
  endtask

  // Output side: random stall before each result, sometimes none at all.
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compares every result with the oldest awaited one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_pixels.size() == 0) begin
        $display("%0t ns: result with none awaited, expected nothing, got %0h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        head = awaited_pixels.pop_front();
        if (m_axis_tdata !== head.pixel) begin
          $display("%0t ns: pixel_out expected %0h, got %0h",
                   $time, head.pixel, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== head.last) begin
          $display("%0t ns: frame_last expected %b, got %b",
                   $time, head.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned goal;
    foreach (above_line[i]) begin
      above_line[i] = '0;
      near_line[i]  = '0;
    end
    foreach (win[i]) win[i] = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes, then the hand-built frames.
    read_check(REG_FRAME_WIDTH, 640);
    read_check(REG_FRAME_HEIGHT, 480);
    cfg_write(REG_FRAME_WIDTH, 3);
    cfg_write(REG_FRAME_HEIGHT, 3);
    foreach (probe_rows[i]) begin
      push_item(probe_rows[i].act, probe_rows[i].pix, probe_rows[i].chk == CHK_FIXED,
                '{probe_rows[i].want_last, probe_rows[i].want_pixel});
    end
    settle();

    // Size extremes: zero sizes, tallest frame cut short, widest frame
    // cut short after the column counter has wrapped, then narrow frames.
    run_setting(0, 0, 2, 0);
    run_setting(1, 16'hffff, 1, 40);
    run_setting(12'hfff, 2, 1, MAX_W + 40);
    run_setting(2, 3, 1, 0);
    run_setting(3, 2, 1, 0);

    goal = items_used + RANDOM_ITEMS;
    while (items_used < goal) random_setting();
    settle();

    if (errors == 0) begin
      $display("[unsharp_mask_3x3] OK");
    end else begin
      $display("[unsharp_mask_3x3] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/usm_pkg.sv
rtl/usm_ram.sv
rtl/usm_out_fifo.sv
rtl/unsharp_mask_3x3.sv
rtl/usm_checker.sv
tb/tb.sv
